@@ sv/sgm_pkg.sv @@
`timescale 1ns / 1ps

package sgm_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int QUEUE_DEPTH = 4;

   localparam int PIXEL_W       = 8;
   localparam int MAG_W         = 8;
   localparam int FRAME_WIDTH_W = 11;
   localparam int FRAME_HEIGHT_W = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int GRAD_W        = 11;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd1024;

   localparam logic [MAG_W-1:0] MAG_MAX = 8'd255;

   // Result slots of one window: upper row with middle or edge column, then the
   // last row with middle or edge column.
   localparam int SLOT_COUNT = 4;

   typedef logic [PIXEL_W-1:0] pix_type;
   typedef pix_type [2:0][2:0] win_type;

   typedef struct packed {
      logic                      we;
      logic [CSR_INDEX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]     data;
   } csr_write_type;

   typedef struct packed {
      win_type                   win;
      logic [SLOT_COUNT-1:0]     mask;
      logic                      r_is1;
      logic                      c_is1;
   } entry_type;

endpackage

@@ sv/sgm_req_if.sv @@
`timescale 1ns / 1ps

interface sgm_req_if;
   logic                         valid;
   logic                         ready;
   logic [sgm_pkg::PIXEL_W-1:0]  pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

@@ sv/sgm_rsp_if.sv @@
`timescale 1ns / 1ps

interface sgm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sgm_pkg::MAG_W-1:0]    magnitude;
   logic                         row_end;
   logic                         frame_end;

   modport source (output valid, output magnitude, output row_end, output frame_end,
                   input ready);
   modport sink (input valid, input magnitude, input row_end, input frame_end,
                 output ready);
endinterface

@@ sv/sgm_front.sv @@
`timescale 1ns / 1ps

module sgm_front #(
   parameter int MAX_WIDTH   = sgm_pkg::MAX_WIDTH,
   parameter int QUEUE_DEPTH = sgm_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   sgm_req_if.sink                            req,
   input  sgm_pkg::csr_write_type             csr,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count,
   output logic                               push,
   output sgm_pkg::entry_type                 push_entry
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WEW = (CW + 1 > sgm_pkg::FRAME_WIDTH_W) ? CW + 1 : sgm_pkg::FRAME_WIDTH_W;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int HW  = sgm_pkg::FRAME_HEIGHT_W;
   localparam int PW  = sgm_pkg::PIXEL_W;

   logic [sgm_pkg::FRAME_WIDTH_W-1:0] width_ff;
   logic [HW-1:0]                     height_ff;
   logic [CW-1:0]                     col_ff;
   logic [HW-1:0]                     row_ff;

   logic [WEW-1:0] w_fw, w_eff, c_ext;
   logic [HW-1:0]  h_eff, r_eff;
   logic [CW-1:0]  c_eff;
   logic           last_col, last_row;
   logic           accept;

   // Stage after the line-store read.
   logic              a_valid_ff;
   logic [PW-1:0]     a_pix_ff;
   logic [CW-1:0]     a_col_ff;
   logic              a_r_ge1_ff, a_r_is1_ff, a_c_ge1_ff, a_c_is1_ff;
   logic              a_last_col_ff, a_last_row_ff;
   logic [2*PW-1:0]   rd_ff;

   // Each entry holds {older line, previous line} for one column.
   logic [2*PW-1:0]   line_mem [MAX_WIDTH];

   sgm_pkg::win_type  win_ff, win_in;
   logic [sgm_pkg::SLOT_COUNT-1:0] mask;

   always_comb begin
      w_fw = WEW'(width_ff);
      if (w_fw < WEW'(2)) begin
         w_eff = WEW'(2);
      end else if (w_fw > WEW'(MAX_WIDTH)) begin
         w_eff = WEW'(MAX_WIDTH);
      end else begin
         w_eff = w_fw;
      end
      c_ext = WEW'(col_ff);
      if (c_ext >= w_eff) begin
         c_eff = CW'(w_eff - WEW'(1));
      end else begin
         c_eff = col_ff;
      end
      last_col = ((WEW'(c_eff) + WEW'(1)) >= w_eff);

      h_eff = (height_ff < HW'(2)) ? HW'(2) : height_ff;
      r_eff = (row_ff >= h_eff) ? (h_eff - HW'(1)) : row_ff;
      last_row = (({1'b0, r_eff} + (HW+1)'(1)) >= {1'b0, h_eff});
   end

   // Room is kept for the item already past the read stage.
   assign req.ready = ((QCW+1)'(queue_count) + (QCW+1)'(a_valid_ff))
                      < (QCW+1)'(QUEUE_DEPTH);
   assign accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sgm_pkg::FRAME_WIDTH_RESET;
         height_ff <= sgm_pkg::FRAME_HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr.we) begin
         unique case (csr.index)
            sgm_pkg::REG_FRAME_WIDTH: begin
               width_ff <= csr.data[sgm_pkg::FRAME_WIDTH_W-1:0];
               col_ff   <= '0;
               row_ff   <= '0;
            end
            sgm_pkg::REG_FRAME_HEIGHT: begin
               height_ff <= csr.data[HW-1:0];
               col_ff    <= '0;
               row_ff    <= '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : (r_eff + HW'(1));
         end else begin
            col_ff <= c_eff + CW'(1);
            row_ff <= r_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff      <= req.pixel;
         a_col_ff      <= c_eff;
         a_r_ge1_ff    <= (r_eff != '0);
         a_r_is1_ff    <= (r_eff == HW'(1));
         a_c_ge1_ff    <= (c_eff != '0);
         a_c_is1_ff    <= (c_eff == CW'(1));
         a_last_col_ff <= last_col;
         a_last_row_ff <= last_row;
         rd_ff         <= line_mem[c_eff];
      end
      // Write-back comes in the cycle after the read; consecutive requests never share
      // a column, so the next read is never to the entry being written.
      if (a_valid_ff) begin
         line_mem[a_col_ff] <= {rd_ff[PW-1:0], a_pix_ff};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = rd_ff[2*PW-1:PW];
      win_in[1][2] = rd_ff[PW-1:0];
      win_in[2][2] = a_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (a_valid_ff) begin
         win_ff <= win_in;
      end
   end

   assign mask = {a_last_row_ff & a_last_col_ff, a_last_row_ff & a_c_ge1_ff,
                  a_last_col_ff, a_c_ge1_ff};

   // Only windows that produce at least one result go to the back end.
   assign push             = a_valid_ff && a_r_ge1_ff && (mask != '0);
   assign push_entry.win   = win_in;
   assign push_entry.mask  = mask;
   assign push_entry.r_is1 = a_r_is1_ff;
   assign push_entry.c_is1 = a_c_is1_ff;

endmodule

@@ sv/sgm_queue.sv @@
`timescale 1ns / 1ps

module sgm_queue #(
   parameter int DEPTH = sgm_pkg::QUEUE_DEPTH,
   parameter int WIDTH = $bits(sgm_pkg::entry_type)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         rd_en,
   output logic [WIDTH-1:0]             rd_data,
   output logic                         rd_valid,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTRW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNTW-1:0]  count_ff;
   logic             do_rd;

   assign do_rd    = rd_en && (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign rd_valid = (count_ff != '0);
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : (wr_ptr_ff + PTRW'(1));
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : (rd_ptr_ff + PTRW'(1));
         end
         count_ff <= count_ff + CNTW'(wr_en) - CNTW'(do_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ sv/sgm_back.sv @@
`timescale 1ns / 1ps

module sgm_back (
   input  logic               clock,
   input  logic               reset,
   input  sgm_pkg::entry_type head,
   input  logic               head_valid,
   output logic               pop,
   sgm_rsp_if.source          rsp
);

   localparam int GW = sgm_pkg::GRAD_W;
   localparam int SC = sgm_pkg::SLOT_COUNT;

   logic [SC-1:0] done_ff;
   logic [SC-1:0] rem, rem_after;
   logic [1:0]    slot;
   logic          issue;

   logic [1:0]    rs [3];
   logic [1:0]    cs [3];
   sgm_pkg::pix_type v [3][3];
   logic signed [GW-1:0] gx, gy;

   logic                 g_valid_ff;
   logic signed [GW-1:0] gx_ff, gy_ff;
   logic                 g_re_ff, g_fe_ff;
   logic                 g_can, out_can;

   logic                 out_valid_ff;
   logic [sgm_pkg::MAG_W-1:0] mag_ff;
   logic                 re_ff, fe_ff;

   logic [GW-1:0] ax, ay, sum;

   assign rem = head.mask & ~done_ff;

   always_comb begin
      if (rem[0]) begin
         slot = 2'd0;
      end else if (rem[1]) begin
         slot = 2'd1;
      end else if (rem[2]) begin
         slot = 2'd2;
      end else begin
         slot = 2'd3;
      end
   end

   assign out_can   = !out_valid_ff || rsp.ready;
   assign g_can     = !g_valid_ff || out_can;
   assign issue     = head_valid && g_can;
   assign rem_after = rem & ~(SC'(1) << slot);
   assign pop       = issue && (rem_after == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else if (issue) begin
         done_ff <= (rem_after == '0) ? '0 : (done_ff | (SC'(1) << slot));
      end
   end

   // Upper-row slots centre on the row above the newest one, last-row slots on
   // the newest row; odd slots sit on the right edge. Borders mirror about the
   // edge pixel.
   always_comb begin
      if (!slot[1]) begin
         rs[0] = head.r_is1 ? 2'd2 : 2'd0;
         rs[1] = 2'd1;
         rs[2] = 2'd2;
      end else begin
         rs[0] = 2'd1;
         rs[1] = 2'd2;
         rs[2] = 2'd1;
      end
      if (!slot[0]) begin
         cs[0] = head.c_is1 ? 2'd2 : 2'd0;
         cs[1] = 2'd1;
         cs[2] = 2'd2;
      end else begin
         cs[0] = 2'd1;
         cs[1] = 2'd2;
         cs[2] = 2'd1;
      end
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            v[a][b] = head.win[rs[a]][cs[b]];
         end
      end
   end

   function automatic logic signed [GW-1:0] sx(input sgm_pkg::pix_type p);
      return $signed({{(GW - sgm_pkg::PIXEL_W){1'b0}}, p});
   endfunction

   always_comb begin
      gx = (sx(v[0][2]) - sx(v[0][0])) + ((sx(v[1][2]) - sx(v[1][0])) <<< 1)
           + (sx(v[2][2]) - sx(v[2][0]));
      gy = (sx(v[2][0]) + (sx(v[2][1]) <<< 1) + sx(v[2][2]))
           - (sx(v[0][0]) + (sx(v[0][1]) <<< 1) + sx(v[0][2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (g_can) begin
         g_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         gx_ff   <= gx;
         gy_ff   <= gy;
         g_re_ff <= slot[0];
         g_fe_ff <= (slot == 2'd3);
      end
   end

   always_comb begin
      ax  = gx_ff[GW-1] ? GW'(-gx_ff) : GW'(gx_ff);
      ay  = gy_ff[GW-1] ? GW'(-gy_ff) : GW'(gy_ff);
      sum = ax + ay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_can) begin
         out_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_can && g_valid_ff) begin
         mag_ff <= (sum > GW'(sgm_pkg::MAG_MAX)) ? sgm_pkg::MAG_MAX
                                                 : sum[sgm_pkg::MAG_W-1:0];
         re_ff  <= g_re_ff;
         fe_ff  <= g_fe_ff;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.magnitude = mag_ff;
   assign rsp.row_end   = re_ff;
   assign rsp.frame_end = fe_ff;

endmodule

@@ sv/sobel_gradient_magnitude_unit.sv @@
`timescale 1ns / 1ps

// Sobel 3x3 edge magnitude over a raster stream of 8-bit gray pixels.
// req_ch carries one pixel per request; rsp_ch returns |Gx|+|Gy| saturated at
// 255, with row_end and frame_end flags. Borders mirror about the edge pixel.
// Frame width and height are written through csr_we/csr_index/csr_wdata while
// the block is idle; any such write restarts the frame at row 0, column 0.
// Row 0 produces no results. Each later request past column 0 produces the
// result centered one row up and one column left, plus the right-edge result
// at the end of a row; on the last row the results of that row follow as
// well, so the final request of a frame yields four results.
// Throughput is one request per cycle while the window queue has room, set by
// the single read and write port of the line store; on the last row a request
// yields up to four results, so there the rate is set by the gradient unit
// producing one result per cycle.
// A four-entry window queue separates the front from the gradient unit, so a
// stalled receiver holds its result and the front keeps accepting until the
// queue fills. Reset clears all control state and sets both dimensions to 1024;
// the line store keeps its contents and needs no clearing pass.
module sobel_gradient_magnitude_unit #(
   parameter int MAX_WIDTH   = sgm_pkg::MAX_WIDTH,
   parameter int QUEUE_DEPTH = sgm_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   sgm_req_if.sink                             req_ch,
   sgm_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [sgm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sgm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   sgm_pkg::csr_write_type              csr;
   sgm_pkg::entry_type                  push_entry, head;
   logic                                push, pop, head_valid;
   logic [$clog2(QUEUE_DEPTH+1)-1:0]    queue_count;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   sgm_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .csr         (csr),
      .queue_count (queue_count),
      .push        (push),
      .push_entry  (push_entry)
   );

   sgm_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(sgm_pkg::entry_type))
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push),
      .wr_data  (push_entry),
      .rd_en    (pop),
      .rd_data  (head),
      .rd_valid (head_valid),
      .count    (queue_count)
   );

   sgm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule
